/* rtl/core/wsd_pkg.sv */
// Shared types, codes and helpers for the websocket frame deframer.
`default_nettype none

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TEXT   = 2'd0,
        ACT_PONG   = 2'd1,
        ACT_CLOSE  = 2'd2,
        ACT_IGNORE = 2'd3
    } action_t;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        logic [3:0] frame_opcode;
        action_t    action;
        logic       last_of_frame;
        logic       cut_off;
    } result_t;

    function automatic action_t action_for(input logic [3:0] op, input logic nonempty);
        action_t act;
        act = ACT_IGNORE;
        if (op == OP_TEXT) begin
            act = nonempty ? ACT_TEXT : ACT_IGNORE;
        end else if (op == OP_PING) begin
            act = ACT_PONG;
        end else if (op == OP_CLOSE) begin
            act = ACT_CLOSE;
        end
        return act;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/websocket_frame_deframer_core.sv */
// Top level of the websocket frame deframer.
//
// Accepts one received byte per clock and parses RFC 6455 frames: header,
// 16- or 64-bit extended length, optional mask key, then unmasked payload
// bytes. Each item gives at most one result, registered and shown on m_*
// in the cycle after the transfer; s_ready stays high while the result register
// is empty or being drained, so a steady one byte per cycle flows when the
// sink keeps m_ready high. The frame state (phase, 64-bit length counter,
// key) updates in the same cycle as the transfer, which sets that one-byte-
// per-cycle rate. A transfer with s_buffer_start high always opens a new
// header; an unfinished frame is then closed with a result flagged cut_off.
`default_nettype none

module websocket_frame_deframer_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_buffer_start,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_payload_byte,
    output logic            m_has_byte,
    output logic [3:0]      m_frame_opcode,
    output logic [1:0]      m_action,
    output logic            m_last_of_frame,
    output logic            m_cut_off
);
    import wsd_pkg::*;

    logic    step;
    logic    res_valid;
    logic    take_ok;
    result_t res;
    result_t m_res;

    assign s_ready = take_ok;
    assign step    = s_valid && take_ok;

    wsd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .data_byte    (s_data_byte),
        .buffer_start (s_buffer_start),
        .res          (res),
        .res_valid    (res_valid)
    );

    wsd_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (res_valid),
        .res     (res),
        .take_ok (take_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_payload_byte  = m_res.payload_byte;
    assign m_has_byte      = m_res.has_byte;
    assign m_frame_opcode  = m_res.frame_opcode;
    assign m_action        = m_res.action;
    assign m_last_of_frame = m_res.last_of_frame;
    assign m_cut_off       = m_res.cut_off;

endmodule

`default_nettype wire

/* rtl/core/wsd_parser.sv */
// Header/payload parser: frame state registers and the per-byte next-state logic.
`default_nettype none

module wsd_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    input  wire logic             buffer_start,
    output wsd_pkg::result_t      res,
    output logic                  res_valid
);
    import wsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [63:0] payload_left_reg, payload_left_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic        is_masked_reg, is_masked_next;
    logic [3:0]  held_opcode_reg, held_opcode_next;
    logic [1:0]  mask_pos_reg, mask_pos_next;

    logic [6:0]  len7;
    logic        len_done;
    logic        hdr_done;
    logic [63:0] payload_dec;
    logic [7:0]  key_byte;

    assign len7        = data_byte[6:0];
    assign payload_dec = payload_left_reg - 64'd1;
    // position 0 uses the most significant key byte
    assign key_byte    = 8'(mask_key_reg >> {~mask_pos_reg, 3'b000});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HDR0;
            len_left_reg     <= '0;
            payload_left_reg <= '0;
            mask_key_reg     <= '0;
            is_masked_reg    <= 1'b0;
            held_opcode_reg  <= '0;
            mask_pos_reg     <= '0;
        end else begin
            phase_reg        <= phase_next;
            len_left_reg     <= len_left_next;
            payload_left_reg <= payload_left_next;
            mask_key_reg     <= mask_key_next;
            is_masked_reg    <= is_masked_next;
            held_opcode_reg  <= held_opcode_next;
            mask_pos_reg     <= mask_pos_next;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        len_left_next     = len_left_reg;
        payload_left_next = payload_left_reg;
        mask_key_next     = mask_key_reg;
        is_masked_next    = is_masked_reg;
        held_opcode_next  = held_opcode_reg;
        mask_pos_next     = mask_pos_reg;
        res               = '0;
        res.action        = ACT_IGNORE;
        res_valid         = 1'b0;
        len_done          = 1'b0;
        hdr_done          = 1'b0;

        if (step) begin
            if (buffer_start && (phase_reg != PH_HDR0)) begin
                // drop the unfinished frame, this byte opens a new header
                res.frame_opcode  = held_opcode_reg;
                res.action        = ACT_IGNORE;
                res.last_of_frame = 1'b1;
                res.cut_off       = 1'b1;
                res_valid         = 1'b1;
                held_opcode_next  = data_byte[3:0];
                phase_next        = PH_HDR1;
            end else begin
                case (phase_reg)
                    PH_HDR1: begin
                        is_masked_next    = data_byte[7];
                        payload_left_next = '0;
                        if (len7 == LEN7_EXT16) begin
                            len_left_next = EXT16_BYTES;
                            phase_next    = PH_EXTLEN;
                        end else if (len7 == LEN7_EXT64) begin
                            len_left_next = EXT64_BYTES;
                            phase_next    = PH_EXTLEN;
                        end else begin
                            payload_left_next = 64'(len7);
                            len_done          = 1'b1;
                        end
                    end
                    PH_EXTLEN: begin
                        payload_left_next = {payload_left_reg[55:0], data_byte};
                        len_left_next     = len_left_reg - 4'd1;
                        len_done          = (len_left_next == 4'd0);
                    end
                    PH_MASK: begin
                        mask_key_next = {mask_key_reg[23:0], data_byte};
                        mask_pos_next = mask_pos_reg + 2'd1;
                        hdr_done      = (mask_pos_next == 2'd0);
                    end
                    PH_PAYLOAD: begin
                        mask_pos_next     = mask_pos_reg + 2'd1;
                        payload_left_next = payload_dec;
                        res.payload_byte  = data_byte ^ (is_masked_reg ? key_byte : 8'h00);
                        res.has_byte      = 1'b1;
                        res.frame_opcode  = held_opcode_reg;
                        res.action        = action_for(held_opcode_reg, 1'b1);
                        res.last_of_frame = (payload_dec == 64'd0);
                        res_valid         = 1'b1;
                        if (payload_dec == 64'd0) begin
                            phase_next = PH_HDR0;
                        end
                    end
                    default: begin
                        held_opcode_next = data_byte[3:0];
                        phase_next       = PH_HDR1;
                    end
                endcase

                if (len_done) begin
                    if (is_masked_next) begin
                        phase_next    = PH_MASK;
                        mask_pos_next = '0;
                        mask_key_next = '0;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end

                if (hdr_done) begin
                    mask_pos_next = '0;
                    if (payload_left_next == 64'd0) begin
                        res.frame_opcode  = held_opcode_reg;
                        res.action        = action_for(held_opcode_reg, 1'b0);
                        res.last_of_frame = 1'b1;
                        res_valid         = 1'b1;
                        phase_next        = PH_HDR0;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/wsd_out_reg.sv */
// Result register with valid/ready handshake toward the downstream side.
`default_nettype none

module wsd_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wsd_pkg::result_t      res,
    output logic                  take_ok,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output wsd_pkg::result_t      m_res
);
    import wsd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // room for a new result when empty or when the held one leaves now
    assign take_ok = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/wsd_checker.sv */
// Port-level assertions for the websocket frame deframer, bound to the top level.
`default_nettype none

module wsd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_payload_byte,
    input wire logic       m_has_byte,
    input wire logic [3:0] m_frame_opcode,
    input wire logic [1:0] m_action,
    input wire logic       m_last_of_frame,
    input wire logic       m_cut_off
);
    import wsd_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte)
            && $stable(m_frame_opcode) && $stable(m_action) && $stable(m_last_of_frame))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_cut_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cut_off |-> m_last_of_frame && !m_has_byte
            && (m_action == ACT_IGNORE) && (m_payload_byte == 8'h00))
        else $error("malformed cut-off result");

    a_text_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_action == ACT_TEXT) |-> m_has_byte && (m_frame_opcode == OP_TEXT))
        else $error("text action without payload byte");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> (m_payload_byte == 8'h00) && m_last_of_frame)
        else $error("byte-less result not zero or not last");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_payload_byte  (m_payload_byte),
    .m_has_byte      (m_has_byte),
    .m_frame_opcode  (m_frame_opcode),
    .m_action        (m_action),
    .m_last_of_frame (m_last_of_frame),
    .m_cut_off       (m_cut_off)
);

`default_nettype wire
